>>> src/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

>>> src/ipc_pkg.sv
package ipc_pkg;

   localparam int DEF_MAX_N = 255;
   localparam int QUERY_W   = 9;
   localparam int COUNT_W   = 52;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_INIT  = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

>>> src/ipc_scratch.sv
module ipc_scratch #(
   parameter int MAX_N  = ipc_pkg::DEF_MAX_N,
   parameter int ADDR_W = $clog2(MAX_N + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       init_we,
   input  logic [ADDR_W-1:0]          init_addr,
   input  logic [ipc_pkg::COUNT_W-1:0] init_data,
   input  logic                       step_issue,
   input  logic [ADDR_W-1:0]          step_addr,
   input  logic [ADDR_W-1:0]          step_lo_addr,
   input  logic                       step_fwd,
   output logic                       sum_valid,
   output logic [ipc_pkg::COUNT_W-1:0] sum
);

   localparam int DEPTH = MAX_N + 1;

   logic [ipc_pkg::COUNT_W-1:0] mem [DEPTH];

   logic                        pipe_v_ff;
   logic [ADDR_W-1:0]           wa_ff;
   logic                        fwd_ff;
   logic [ipc_pkg::COUNT_W-1:0] rd_a_ff;
   logic [ipc_pkg::COUNT_W-1:0] rd_b_ff;
   logic [ipc_pkg::COUNT_W-1:0] last_sum_ff;
   logic [ipc_pkg::COUNT_W-1:0] addend;
   logic                        we;
   logic [ADDR_W-1:0]           wa;
   logic [ipc_pkg::COUNT_W-1:0] wd;

   // With part size one the lower entry is the one written in the cycle before.
   assign addend    = fwd_ff ? last_sum_ff : rd_b_ff;
   assign sum       = rd_a_ff + addend;
   assign sum_valid = pipe_v_ff;

   assign we = pipe_v_ff | init_we;
   assign wa = pipe_v_ff ? wa_ff : init_addr;
   assign wd = pipe_v_ff ? sum : init_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (step_issue) begin
         rd_a_ff <= mem[step_addr];
         rd_b_ff <= mem[step_lo_addr];
         wa_ff   <= step_addr;
         fwd_ff  <= step_fwd;
      end
      if (pipe_v_ff) begin
         last_sum_ff <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= 1'b0;
      end else begin
         pipe_v_ff <= step_issue;
      end
   end

endmodule

>>> src/integer_partition_count_core.sv
// Partition count engine: each query n returns p(n), the number of ways to
// write n as an unordered sum of positive integers (0 for a query of 0; a
// query above MAX_N sets range_error with a count of 0). The count is built
// in a scratch memory by adding in part sizes j = 1..n one after another,
// one read-add-write of entry k per cycle within a pass through a single
// 52-bit adder. A query first seeds entries 0..n of the memory, then makes
// one update per (j, k) pair, a drain step after each part size, and a final
// load of the output register. Queries of 0 or out of range skip the memory
// and go straight to the output register. One query is processed at a time;
// the result sits in an output register so the next query can start while
// it waits.
module integer_partition_count_core #(
   parameter int MAX_N = ipc_pkg::DEF_MAX_N
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ipc_pkg::QUERY_W-1:0]  req_query_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ipc_pkg::COUNT_W-1:0]  rsp_partition_count,
   output logic                         rsp_range_error
);

   localparam int ADDR_W = $clog2(MAX_N + 1);

   ipc_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]           n_ff, n_in;
   logic [ADDR_W-1:0]           j_ff, j_in;
   logic [ADDR_W-1:0]           k_ff, k_in;
   logic [ipc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        err_ff, err_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ipc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_err_ff, rsp_err_in;

   logic                        accept;
   logic                        out_of_range;
   logic                        init_we;
   logic [ipc_pkg::COUNT_W-1:0] init_data;
   logic                        step_issue;
   logic [ADDR_W-1:0]           step_lo_addr;
   logic                        step_fwd;
   logic                        sum_valid;
   logic [ipc_pkg::COUNT_W-1:0] sum;
   logic                        unload;

   assign req_ready    = (state_ff == ipc_pkg::ST_IDLE);
   assign accept       = req_valid & req_ready;
   assign out_of_range = req_query_value > ipc_pkg::QUERY_W'(MAX_N);

   assign init_we      = (state_ff == ipc_pkg::ST_INIT);
   assign init_data    = (k_ff == '0) ? ipc_pkg::COUNT_W'(1) : '0;
   assign step_issue   = (state_ff == ipc_pkg::ST_ISSUE);
   assign step_lo_addr = k_ff - j_ff;
   assign step_fwd     = (j_ff == ADDR_W'(1)) && (k_ff != ADDR_W'(1));
   assign unload       = (state_ff == ipc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   ipc_scratch #(
      .MAX_N  (MAX_N),
      .ADDR_W (ADDR_W)
   ) u_scratch (
      .clock        (clock),
      .reset        (reset),
      .init_we      (init_we),
      .init_addr    (k_ff),
      .init_data    (init_data),
      .step_issue   (step_issue),
      .step_addr    (k_ff),
      .step_lo_addr (step_lo_addr),
      .step_fwd     (step_fwd),
      .sum_valid    (sum_valid),
      .sum          (sum)
   );

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      count_in = count_ff;
      err_in   = err_ff;

      // The only update in the last pass writes entry n: that is the answer.
      if (sum_valid && (j_ff == n_ff)) begin
         count_in = sum;
      end

      case (state_ff)
         ipc_pkg::ST_IDLE: begin
            if (accept) begin
               n_in     = req_query_value[ADDR_W-1:0];
               k_in     = '0;
               count_in = '0;
               err_in   = out_of_range;
               if (out_of_range || (req_query_value == '0)) begin
                  state_in = ipc_pkg::ST_DONE;
               end else begin
                  state_in = ipc_pkg::ST_INIT;
               end
            end
         end
         ipc_pkg::ST_INIT: begin
            if (k_ff == n_ff) begin
               j_in     = ADDR_W'(1);
               k_in     = ADDR_W'(1);
               state_in = ipc_pkg::ST_ISSUE;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
         ipc_pkg::ST_ISSUE: begin
            if (k_ff == n_ff) begin
               state_in = ipc_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
         ipc_pkg::ST_DRAIN: begin
            // Let the last write of this pass land before the next pass reads.
            if (j_ff == n_ff) begin
               state_in = ipc_pkg::ST_DONE;
            end else begin
               j_in     = j_ff + ADDR_W'(1);
               k_in     = j_ff + ADDR_W'(1);
               state_in = ipc_pkg::ST_ISSUE;
            end
         end
         ipc_pkg::ST_DONE: begin
            if (unload) begin
               state_in = ipc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ipc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      if (unload) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
         rsp_err_in   = err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_partition_count = rsp_count_ff;
   assign rsp_range_error     = rsp_err_ff;

endmodule

>>> src/ipc_checker.sv
`include "assert_macros.svh"

module ipc_checker #(
   parameter int MAX_N = ipc_pkg::DEF_MAX_N
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [ipc_pkg::QUERY_W-1:0]  req_query_value,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ipc_pkg::COUNT_W-1:0]  rsp_partition_count,
   input logic                         rsp_range_error
);

   // A held result stays offered and unchanged.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset,
      rsp_valid && !rsp_ready |=> $stable(rsp_partition_count))

   // An accepted item keeps the block busy on the next cycle.
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   // An out-of-range query always reports a zero count.
   `ASSERT_NEVER(a_err_zero, clock, reset,
      rsp_valid && rsp_range_error && (rsp_partition_count != '0))

   // While no result is offered, none can appear in the cycle right after an in-range nonzero query.
   `ASSERT_CLK(a_no_early_rsp, clock, reset,
      req_valid && req_ready && (req_query_value != '0) && !rsp_valid
      && (req_query_value <= ipc_pkg::QUERY_W'(MAX_N)) |=> !rsp_valid)

endmodule

bind integer_partition_count_core ipc_checker #(.MAX_N(MAX_N)) u_ipc_checker (.*);

>>> sim/integer_partition_count_core_tb.sv
module integer_partition_count_core_tb;

   localparam int MAX_N          = ipc_pkg::DEF_MAX_N;
   localparam int STALL_LIMIT    = 200000;
   localparam int RANDOM_QUERIES = 100;
   localparam int DIRECTED_ROWS  = 16;

   typedef struct packed {
      logic [ipc_pkg::COUNT_W-1:0] count;
      logic                        range_error;
   } partition_result_type;

   typedef struct packed {
      logic [ipc_pkg::QUERY_W-1:0] query;
      logic                        typed;
      partition_result_type        result;
   } directed_row_type;

   // Rows with typed = 0 take their expectation from the predictor.
   localparam directed_row_type DIRECTED_QUERIES [DIRECTED_ROWS] = '{
      '{9'd0,   1'b1, '{52'd0, 1'b0}},
      '{9'd1,   1'b1, '{52'd1, 1'b0}},
      '{9'd2,   1'b1, '{52'd2, 1'b0}},
      '{9'd3,   1'b1, '{52'd3, 1'b0}},
      '{9'd4,   1'b1, '{52'd5, 1'b0}},
      '{9'd5,   1'b1, '{52'd7, 1'b0}},
      '{9'd255, 1'b0, '{52'd0, 1'b0}},
      '{9'd256, 1'b1, '{52'd0, 1'b1}},
      '{9'd511, 1'b1, '{52'd0, 1'b1}},
      '{9'd300, 1'b1, '{52'd0, 1'b1}},
      '{9'd254, 1'b0, '{52'd0, 1'b0}},
      '{9'd170, 1'b0, '{52'd0, 1'b0}},
      '{9'd85,  1'b0, '{52'd0, 1'b0}},
      '{9'd128, 1'b0, '{52'd0, 1'b0}},
      '{9'd100, 1'b0, '{52'd0, 1'b0}},
      '{9'd10,  1'b0, '{52'd0, 1'b0}}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [ipc_pkg::QUERY_W-1:0] req_query_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [ipc_pkg::COUNT_W-1:0] rsp_partition_count;
   logic                        rsp_range_error;

   logic [ipc_pkg::COUNT_W-1:0] scratch_counts [MAX_N+1];
   partition_result_type        expected_results [$];
   int                          failures = 0;
   int                          results_checked = 0;
   int                          range_errors_seen = 0;
   int                          idle_cycles = 0;
   int                          rsp_hold = 0;
   int                          largest_query = 0;
   bit                          no_stalls = 1'b0;

   integer_partition_count_core #(.MAX_N(MAX_N)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_query_value     (req_query_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_partition_count (rsp_partition_count),
      .rsp_range_error     (rsp_range_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Add in part sizes one by one on the scratch copy; out-of-range leaves it alone.
   function automatic partition_result_type predict_partition(
         logic [ipc_pkg::QUERY_W-1:0] n);
      partition_result_type r;
      int m;
      r.count = '0;
      r.range_error = 1'b0;
      m = int'(n);
      if (m > MAX_N) begin
         r.range_error = 1'b1;
      end else if (m != 0) begin
         scratch_counts[0] = ipc_pkg::COUNT_W'(1);
         for (int k = 1; k <= m; k++)
            scratch_counts[k] = '0;
         for (int j = 1; j <= m; j++)
            for (int k = j; k <= m; k++)
               scratch_counts[k] = scratch_counts[k] + scratch_counts[k-j];
         r.count = scratch_counts[m];
      end
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Keep most queries small so the run stays short; a few go up to MAX_N.
   function automatic logic [ipc_pkg::QUERY_W-1:0] random_query();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12)
         return ipc_pkg::QUERY_W'($urandom_range(MAX_N + 1, (1 << ipc_pkg::QUERY_W) - 1));
      if (r < 20) return ipc_pkg::QUERY_W'($urandom_range(41, MAX_N));
      return ipc_pkg::QUERY_W'($urandom_range(0, 40));
   endfunction

   task automatic send_query(input logic [ipc_pkg::QUERY_W-1:0] value,
                             input partition_result_type typed_result,
                             input bit use_typed);
      int gap;
      gap = no_stalls ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_query_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (use_typed)
         expected_results.push_back(typed_result);
      else
         expected_results.push_back(predict_partition(value));
      if (int'(value) <= MAX_N && int'(value) > largest_query)
         largest_query = int'(value);
   endtask

   // Hold the sender until every outstanding item has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!no_stalls && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= idle_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      partition_result_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item, count %0d range_error %0b",
                        $time, rsp_partition_count, rsp_range_error);
               failures++;
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (want.range_error)
                  range_errors_seen++;
               if (rsp_partition_count !== want.count) begin
                  $display("%0t: partition_count expected %0d actual %0d",
                           $time, want.count, rsp_partition_count);
                  failures++;
               end
               if (rsp_range_error !== want.range_error) begin
                  $display("%0t: range_error expected %0b actual %0b",
                           $time, want.range_error, rsp_range_error);
                  failures++;
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("integer_partition_count_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      partition_result_type        none;
      logic [ipc_pkg::QUERY_W-1:0] q;
      none = '0;
      for (int i = 0; i <= MAX_N; i++)
         scratch_counts[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_query(DIRECTED_QUERIES[i].query, DIRECTED_QUERIES[i].result,
                    DIRECTED_QUERIES[i].typed);
      wait_for_drain();

      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         // run a back-to-back stretch with no idling on either side
         no_stalls = (i >= 40 && i < 60);
         if (i == 70)
            wait_for_drain();
         q = random_query();
         send_query(q, none, 1'b0);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d directed and %0d random queries, %0d results checked, %0d out of range.",
               DIRECTED_ROWS, RANDOM_QUERIES, results_checked, range_errors_seen);
      $display("Largest in-range query %0d, %0d mismatches.", largest_query, failures);
      if (failures == 0)
         $display("integer_partition_count_core verification clean");
      else
         $display("integer_partition_count_core verification failed");
      $finish;
   end

endmodule
